FILE: rtl/pmo_pkg.sv
// ----------------------------------------------------------------------------
// pmo_pkg
// Shared widths, reset values and rounding helper for the polyline mitre
// offset block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmo_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int HW_W  = 14;
    localparam int LIM_W = 8;

    localparam logic [HW_W-1:0]  HALF_WIDTH_RST  = 14'd410;
    localparam logic [LIM_W-1:0] MITRE_LIMIT_RST = 8'd64;

    // register indexes on the configuration channel
    localparam logic CFG_HALF_WIDTH  = 1'b0;
    localparam logic CFG_MITRE_LIMIT = 1'b1;

    // square root unit
    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;

    // divider unit
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 24;

    localparam int UNIT_ONE = 16384;
    localparam int COS_EPS  = 26844;

    // v / 2^sh, rounded to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                  input int unsigned sh);
        logic [63:0] m;
        logic [63:0] q;
        m = v[63] ? 64'(-v) : 64'(v);
        q = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pmo_sqrt.sv
// ----------------------------------------------------------------------------
// pmo_sqrt
// Bit-serial integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmo_sqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [pmo_pkg::SQ_W-1:0]     radicand,
    output logic                              done,
    output logic [pmo_pkg::ROOT_W-1:0]        root
);
    import pmo_pkg::*;

    logic [SQ_W-1:0] s_reg;
    logic [SQ_W-1:0] r_reg;
    logic [SQ_W-1:0] bit_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [SQ_W-1:0] trial;

    assign trial = r_reg + bit_reg;
    assign done  = done_reg;
    assign root  = r_reg[ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            s_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end else if (busy_reg) begin
            if (s_reg >= trial) begin
                s_reg <= s_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pmo_div.sv
// ----------------------------------------------------------------------------
// pmo_div
// Restoring divider, one quotient bit per cycle, fixed quotient width.
// ----------------------------------------------------------------------------
`default_nettype none

module pmo_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [pmo_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [pmo_pkg::DIV_DEN_W-1:0] den,
    output logic                               done,
    output logic [pmo_pkg::DIV_Q_W-1:0]        quo
);
    import pmo_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   sh_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   r2;
    logic                 fits;

    assign r2   = {rem_reg, sh_reg[DIV_Q_W-1]};
    assign fits = r2 >= {1'b0, den_reg};
    assign done = done_reg;
    assign quo  = sh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
            sh_reg  <= num[DIV_Q_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? DIV_DEN_W'(r2 - {1'b0, den_reg}) : r2[DIV_DEN_W-1:0];
            sh_reg  <= {sh_reg[DIV_Q_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/polyline_mitre_offset.sv
// ----------------------------------------------------------------------------
// polyline_mitre_offset
// Left and right offset points of a streamed polyline with mitred joins.
// ----------------------------------------------------------------------------
// Points come in on s_ (tdata = x, y; tlast marks a polyline's last point).
// For each point one offset pair leaves on m_ (tdata = left x, left y,
// right x, right y; tlast on the pair of the last point). Results lag by one
// point; the last point gives two pairs, a lone point gives none.
// cfg_ writes half_width (index 0) and mitre_limit (index 1); write only
// while idle.
// One pair takes three unit vectors, each a normalising shift, a 31-step
// square root and two 24-step divisions, then up to two more divisions
// for the offset, all on one multiplier, one square root unit and one
// divider. A zero-length direction skips its unit vector. s_tready is
// high only between items.
// A finished pair waits in the output register; while m_tready is low the
// sequencer holds before writing the next pair.
// Synchronous reset clears the held points, the sequencer and the output
// valid, and loads half_width = 410 and mitre_limit = 64.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_mitre_offset #(
    parameter int COORD_BITS = pmo_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // point_x, point_y
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                  s_tlast,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // left_x, left_y, right_x, right_y
    output logic [((4*COORD_BITS+7)/8)*8-1:0]          m_tdata,
    output logic                                       m_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic                                  cfg_index,
    input  wire logic [pmo_pkg::HW_W-1:0]              cfg_data
);
    import pmo_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int OUT_W = ((4*CB+7)/8)*8;
    localparam int DW    = CB + 1;
    localparam int VW    = 34;
    localparam int UW    = 16;
    localparam int OW    = 26;
    localparam int SUM_W = ((CB > OW) ? CB : OW) + 1;

    localparam logic [1:0] MODE_NEAR = 2'd0;
    localparam logic [1:0] MODE_FALL = 2'd1;
    localparam logic [1:0] MODE_ORD  = 2'd2;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-CB+1){1'b1}}, {(CB-1){1'b0}}};

    typedef enum logic [17:0] {
        ST_IDLE  = 18'h00001,
        ST_LOAD  = 18'h00002,
        ST_NORM  = 18'h00004,
        ST_SQX   = 18'h00008,
        ST_SQY   = 18'h00010,
        ST_SQS   = 18'h00020,
        ST_ROOT  = 18'h00040,
        ST_UDIV  = 18'h00080,
        ST_UWAIT = 18'h00100,
        ST_COS1  = 18'h00200,
        ST_COS2  = 18'h00400,
        ST_COS3  = 18'h00800,
        ST_COS4  = 18'h01000,
        ST_MODE  = 18'h02000,
        ST_OMUL  = 18'h04000,
        ST_OSTEP = 18'h08000,
        ST_OWAIT = 18'h10000,
        ST_EMIT  = 18'h20000
    } state_t;

    function automatic logic [CB-1:0] sat_c(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[CB-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[CB-1:0];
        end
        return v[CB-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [HW_W-1:0]  hw_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [1:0]       seen_reg;
    logic [1:0]       u_reg;
    logic             k_reg;
    logic [1:0]       mode_reg;
    logic             last_pend_reg;
    logic             final_reg;
    logic             m_tvalid_reg;
    logic             osign_reg;

    logic signed [CB-1:0] older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic signed [CB-1:0] here_x_reg, here_y_reg;
    logic signed [DW-1:0] inc_x_reg, inc_y_reg, outd_x_reg, outd_y_reg;
    logic signed [VW-1:0] vx_reg, vy_reg;
    logic signed [63:0]   mul_reg, acc_reg;
    logic [ROOT_W-1:0]    len_reg;
    logic signed [UW-1:0] ux_reg;
    logic signed [UW-1:0] ax_reg, ay_reg, bx_reg, by_reg, mx_reg, my_reg;
    logic signed [31:0]   c_reg;
    logic signed [OW-1:0] ox_reg, oy_reg;
    logic [OUT_W-1:0]     m_tdata_reg;
    logic                 m_tlast_reg;

    logic signed [CB-1:0] px, py;
    logic signed [DW-1:0] dx, dy;
    logic                 in_acc, slot_free;
    logic [VW-1:0]        magx, magy;
    logic                 vzero, vbig, vsmall;
    logic [31:0]          ac;
    logic signed [31:0]   mul_a, mul_b;
    logic signed [31:0]   mh;
    logic [28:0]          mh_mag;
    logic signed [UW-1:0] uq;
    logic signed [OW-1:0] oq;
    logic                 near, fall;

    logic                 sq_start, sq_done;
    logic [SQ_W-1:0]      sq_in;
    logic [ROOT_W-1:0]    sq_root;
    logic                 dv_start, dv_done;
    logic [DIV_NUM_W-1:0] dv_num;
    logic [DIV_DEN_W-1:0] dv_den;
    logic [DIV_Q_W-1:0]   dv_quo;

    logic signed [SUM_W-1:0] hx, hy, ex, ey;

    assign px = s_tdata[CB-1:0];
    assign py = s_tdata[2*CB-1:CB];
    assign dx = DW'(px) - DW'(newer_x_reg);
    assign dy = DW'(py) - DW'(newer_y_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign slot_free = !m_tvalid_reg || m_tready;

    assign magx   = vx_reg[VW-1] ? VW'(-vx_reg) : VW'(vx_reg);
    assign magy   = vy_reg[VW-1] ? VW'(-vy_reg) : VW'(vy_reg);
    assign vzero  = (vx_reg == '0) && (vy_reg == '0);
    assign vbig   = (magx[VW-1:30] != '0) || (magy[VW-1:30] != '0);
    assign vsmall = (magx[VW-1:29] == '0) && (magy[VW-1:29] == '0);

    assign ac     = c_reg[31] ? 32'(-c_reg) : 32'(c_reg);
    assign near   = ac < 32'(COS_EPS);
    assign fall   = (mul_reg[63:32] == '0);
    assign mh     = mul_reg[31:0];
    assign mh_mag = mh[31] ? 29'(-mh) : 29'(mh);

    assign uq = dv_quo[UW-1:0];
    assign oq = OW'(dv_quo);

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX: begin
                mul_a = vx_reg[31:0];
                mul_b = vx_reg[31:0];
            end
            ST_SQY: begin
                mul_a = vy_reg[31:0];
                mul_b = vy_reg[31:0];
            end
            ST_COS1: begin
                mul_a = 32'(mx_reg);
                mul_b = -32'(ay_reg);
            end
            ST_COS2: begin
                mul_a = 32'(my_reg);
                mul_b = 32'(ax_reg);
            end
            ST_COS4: begin
                mul_a = $signed(ac);
                mul_b = $signed({24'd0, lim_reg});
            end
            ST_OMUL: begin
                if (mode_reg == MODE_FALL) begin
                    mul_a = k_reg ? 32'(bx_reg) : -32'(by_reg);
                end else begin
                    mul_a = k_reg ? 32'(my_reg) : 32'(mx_reg);
                end
                mul_b = $signed({18'd0, hw_reg});
            end
            ST_OSTEP: begin
                mul_a = mh;
                mul_b = $signed({24'd0, lim_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sq_start = (state_reg == ST_SQS);
    assign sq_in    = acc_reg[SQ_W-1:0] + mul_reg[SQ_W-1:0];
    assign dv_start = (state_reg == ST_UDIV) ||
                      ((state_reg == ST_OSTEP) && (mode_reg == MODE_ORD));

    always_comb begin
        if (state_reg == ST_UDIV) begin
            dv_num = {4'd0, (k_reg ? magy[29:0] : magx[29:0]), 14'd0} +
                     DIV_NUM_W'(len_reg[ROOT_W-1:1]);
            dv_den = DIV_DEN_W'(len_reg);
        end else begin
            dv_num = {5'd0, mh_mag, 14'd0} + DIV_NUM_W'(ac[31:1]);
            dv_den = ac;
        end
    end

    pmo_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    pmo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .num     (dv_num),
        .den     (dv_den),
        .done    (dv_done),
        .quo     (dv_quo)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (seen_reg != 2'd0)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_NORM;
            ST_NORM: begin
                if (vzero) begin
                    state_next = (u_reg == 2'd2) ? ST_COS1 : ST_LOAD;
                end else if (!vbig && !vsmall) begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SQS;
            ST_SQS:  state_next = ST_ROOT;
            ST_ROOT: begin
                if (sq_done) begin
                    state_next = ST_UDIV;
                end
            end
            ST_UDIV: state_next = ST_UWAIT;
            ST_UWAIT: begin
                if (dv_done) begin
                    if (!k_reg) begin
                        state_next = ST_UDIV;
                    end else begin
                        state_next = (u_reg == 2'd2) ? ST_COS1 : ST_LOAD;
                    end
                end
            end
            ST_COS1: state_next = ST_COS2;
            ST_COS2: state_next = ST_COS3;
            ST_COS3: state_next = ST_COS4;
            ST_COS4: state_next = ST_MODE;
            ST_MODE: state_next = ST_OMUL;
            ST_OMUL: state_next = ST_OSTEP;
            ST_OSTEP: begin
                if (mode_reg == MODE_FALL) begin
                    state_next = k_reg ? ST_EMIT : ST_OMUL;
                end else begin
                    state_next = ST_OWAIT;
                end
            end
            ST_OWAIT: begin
                if ((mode_reg == MODE_NEAR) || dv_done) begin
                    state_next = k_reg ? ST_EMIT : ST_OMUL;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = last_pend_reg ? ST_LOAD : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hw_reg        <= HALF_WIDTH_RST;
            lim_reg       <= MITRE_LIMIT_RST;
            seen_reg      <= 2'd0;
            u_reg         <= 2'd0;
            k_reg         <= 1'b0;
            mode_reg      <= MODE_ORD;
            last_pend_reg <= 1'b0;
            final_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            older_x_reg   <= '0;
            older_y_reg   <= '0;
            newer_x_reg   <= '0;
            newer_y_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_HALF_WIDTH:  hw_reg  <= cfg_data;
                    CFG_MITRE_LIMIT: lim_reg <= cfg_data[LIM_W-1:0];
                    default:         hw_reg  <= hw_reg;
                endcase
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        newer_x_reg <= px;
                        newer_y_reg <= py;
                        if (seen_reg == 2'd0) begin
                            seen_reg <= s_tlast ? 2'd0 : 2'd1;
                        end else begin
                            older_x_reg   <= newer_x_reg;
                            older_y_reg   <= newer_y_reg;
                            seen_reg      <= s_tlast ? 2'd0 : 2'd2;
                            last_pend_reg <= s_tlast;
                            final_reg     <= 1'b0;
                            u_reg         <= 2'd0;
                        end
                    end
                end
                ST_LOAD: k_reg <= 1'b0;
                ST_NORM: begin
                    if (vzero) begin
                        u_reg <= u_reg + 1'b1;
                    end
                end
                ST_UWAIT: begin
                    if (dv_done) begin
                        k_reg <= !k_reg;
                        if (k_reg) begin
                            u_reg <= u_reg + 1'b1;
                        end
                    end
                end
                ST_MODE: begin
                    k_reg <= 1'b0;
                    if (near) begin
                        mode_reg <= MODE_NEAR;
                    end else if (fall) begin
                        mode_reg <= MODE_FALL;
                    end else begin
                        mode_reg <= MODE_ORD;
                    end
                end
                ST_OSTEP: begin
                    if (mode_reg == MODE_FALL) begin
                        k_reg <= 1'b1;
                    end
                end
                ST_OWAIT: begin
                    if ((mode_reg == MODE_NEAR) || dv_done) begin
                        k_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (last_pend_reg) begin
                            last_pend_reg <= 1'b0;
                            final_reg     <= 1'b1;
                            u_reg         <= 2'd0;
                        end
                    end
                end
                default: k_reg <= k_reg;
            endcase
        end
    end

    assign hx = SUM_W'(here_x_reg);
    assign hy = SUM_W'(here_y_reg);
    assign ex = SUM_W'(ox_reg);
    assign ey = SUM_W'(oy_reg);

    // datapath
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    here_x_reg <= newer_x_reg;
                    here_y_reg <= newer_y_reg;
                    outd_x_reg <= dx;
                    outd_y_reg <= dy;
                    if (seen_reg == 2'd1) begin
                        inc_x_reg <= dx;
                        inc_y_reg <= dy;
                    end else begin
                        inc_x_reg <= DW'(newer_x_reg) - DW'(older_x_reg);
                        inc_y_reg <= DW'(newer_y_reg) - DW'(older_y_reg);
                    end
                end
            end
            ST_LOAD: begin
                case (u_reg)
                    2'd0: begin
                        vx_reg <= VW'(inc_x_reg);
                        vy_reg <= VW'(inc_y_reg);
                    end
                    2'd1: begin
                        vx_reg <= VW'(outd_x_reg);
                        vy_reg <= VW'(outd_y_reg);
                    end
                    default: begin
                        vx_reg <= -(VW'(ay_reg) + VW'(by_reg));
                        vy_reg <= VW'(ax_reg) + VW'(bx_reg);
                    end
                endcase
            end
            ST_NORM: begin
                if (vzero) begin
                    case (u_reg)
                        2'd0: begin
                            ax_reg <= UW'(UNIT_ONE);
                            ay_reg <= '0;
                        end
                        2'd1: begin
                            bx_reg <= UW'(UNIT_ONE);
                            by_reg <= '0;
                        end
                        default: begin
                            mx_reg <= UW'(UNIT_ONE);
                            my_reg <= '0;
                        end
                    endcase
                end else if (vbig) begin
                    vx_reg <= (vx_reg + $signed(VW'(vx_reg[VW-1]))) >>> 1;
                    vy_reg <= (vy_reg + $signed(VW'(vy_reg[VW-1]))) >>> 1;
                end else if (vsmall) begin
                    vx_reg <= vx_reg <<< 1;
                    vy_reg <= vy_reg <<< 1;
                end
            end
            ST_SQY: acc_reg <= mul_reg;
            ST_ROOT: begin
                if (sq_done) begin
                    len_reg <= sq_root;
                end
            end
            ST_UWAIT: begin
                if (dv_done) begin
                    if (!k_reg) begin
                        ux_reg <= vx_reg[VW-1] ? -uq : uq;
                    end else begin
                        case (u_reg)
                            2'd0: begin
                                ax_reg <= ux_reg;
                                ay_reg <= vy_reg[VW-1] ? -uq : uq;
                            end
                            2'd1: begin
                                bx_reg <= ux_reg;
                                by_reg <= vy_reg[VW-1] ? -uq : uq;
                            end
                            default: begin
                                mx_reg <= ux_reg;
                                my_reg <= vy_reg[VW-1] ? -uq : uq;
                            end
                        endcase
                    end
                end
            end
            ST_COS2: acc_reg <= mul_reg;
            ST_COS3: c_reg <= acc_reg[31:0] + mul_reg[31:0];
            ST_OSTEP: begin
                osign_reg <= mh[31] ^ c_reg[31];
                if (mode_reg == MODE_FALL) begin
                    if (k_reg) begin
                        oy_reg <= OW'(rnd_sh(mul_reg, 14));
                    end else begin
                        ox_reg <= OW'(rnd_sh(mul_reg, 14));
                    end
                end
            end
            ST_OWAIT: begin
                if (mode_reg == MODE_NEAR) begin
                    if (k_reg) begin
                        oy_reg <= OW'(rnd_sh(mul_reg, 18));
                    end else begin
                        ox_reg <= OW'(rnd_sh(mul_reg, 18));
                    end
                end else if (dv_done) begin
                    if (k_reg) begin
                        oy_reg <= osign_reg ? -oq : oq;
                    end else begin
                        ox_reg <= osign_reg ? -oq : oq;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_tdata_reg <= OUT_W'({sat_c(hy - ey), sat_c(hx - ex),
                                           sat_c(hy + ey), sat_c(hx + ex)});
                    m_tlast_reg <= final_reg;
                    if (last_pend_reg) begin
                        here_x_reg <= newer_x_reg;
                        here_y_reg <= newer_y_reg;
                        inc_x_reg  <= outd_x_reg;
                        inc_y_reg  <= outd_y_reg;
                    end
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

FILE: sim/tb_polyline_mitre_offset.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyline_mitre_offset
// Self-checking bench for the polyline mitre offset block.
// ----------------------------------------------------------------------------
// Polylines are streamed in with random bursts and gaps, and the output side
// stalls on a pattern of its own. An in-bench fixed-point model predicts
// each offset pair. Every accepted pair is checked field by field against
// the oldest prediction. Runs go through several half-width and mitre-limit
// settings with both half-width extremes, and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_polyline_mitre_offset;
    import pmo_pkg::*;

    localparam int  N_ITEMS    = 1700;
    localparam int  DRAIN      = 1000;
    localparam longint LIMIT   = 8_000_000;
    localparam longint ONE_U   = 16384;
    localparam longint COS_MIN = 26844;

    typedef struct packed {
        logic       fin;
        logic [15:0] ry;
        logic [15:0] rx;
        logic [15:0] ly;
        logic [15:0] lx;
    } pair_t;

    logic        aclk;
    logic        aresetn;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [HW_W-1:0] cfg_data;

    polyline_mitre_offset dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // model state
    longint half_w;
    longint mlimit;
    longint old_x, old_y, cur_x, cur_y;
    int     held;

    pair_t  pending_pairs[$];
    int     mismatches;
    int     items_sent;
    longint cycles;
    int     burst_left;
    int     hold_cycles;
    bit     rx_always;
    bit     tx_no_gaps;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint rdiv(input longint num, input longint den);
        longint un, q;
        un = num < 0 ? -num : num;
        q  = (un + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint isqrt64(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint absl(input longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic unit_vec(input longint dx, input longint dy,
                            output longint ux, output longint uy);
        longint len;
        if (dx == 0 && dy == 0) begin
            ux = ONE_U;
            uy = 0;
        end else begin
            while (absl(dx) >= (64'sd1 <<< 30) || absl(dy) >= (64'sd1 <<< 30)) begin
                dx = dx / 2;
                dy = dy / 2;
            end
            while (absl(dx) < (64'sd1 <<< 29) && absl(dy) < (64'sd1 <<< 29)) begin
                dx = dx * 2;
                dy = dy * 2;
            end
            len = isqrt64(dx * dx + dy * dy);
            ux = rdiv(dx * ONE_U, len);
            uy = rdiv(dy * ONE_U, len);
        end
    endtask

    function automatic logic [15:0] clip(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic predict_pair(input longint hx, input longint hy,
                                input longint px, input longint py,
                                input longint nx, input longint ny, input bit fin);
        longint ax, ay, bx, by, mx, my, c, ac, ox, oy;
        pair_t  p;
        unit_vec(px, py, ax, ay);
        unit_vec(nx, ny, bx, by);
        unit_vec(-ay - by, ax + bx, mx, my);
        c  = mx * (-ay) + my * ax;
        ac = absl(c);
        if (ac < COS_MIN) begin
            ox = rdiv(mx * half_w * mlimit, 64'sd1 <<< 18);
            oy = rdiv(my * half_w * mlimit, 64'sd1 <<< 18);
        end else if (ac * mlimit < (64'sd1 <<< 32)) begin
            ox = rdiv(-by * half_w, ONE_U);
            oy = rdiv(bx * half_w, ONE_U);
        end else begin
            ox = rdiv(mx * half_w * ONE_U, ac);
            oy = rdiv(my * half_w * ONE_U, ac);
            if (c < 0) begin
                ox = -ox;
                oy = -oy;
            end
        end
        p.lx  = clip(hx + ox);
        p.ly  = clip(hy + oy);
        p.rx  = clip(hx - ox);
        p.ry  = clip(hy - oy);
        p.fin = fin;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    task automatic track_point(input logic [15:0] x, input logic [15:0] y, input bit last);
        longint px, py, dx, dy;
        px = longint'($signed(x));
        py = longint'($signed(y));
        if (held == 0) begin
            cur_x = px;
            cur_y = py;
            held  = last ? 0 : 1;
        end else begin
            dx = px - cur_x;
            dy = py - cur_y;
            if (held == 1)
                predict_pair(cur_x, cur_y, dx, dy, dx, dy, 1'b0);
            else
                predict_pair(cur_x, cur_y, cur_x - old_x, cur_y - old_y, dx, dy, 1'b0);
            old_x = cur_x;
            old_y = cur_y;
            cur_x = px;
            cur_y = py;
            held  = 2;
            if (last) begin
                predict_pair(cur_x, cur_y, dx, dy, dx, dy, 1'b1);
                held = 0;
            end
        end
    endtask

    // ---------------- drivers ----------------
    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!tx_no_gaps) begin
                gap = $urandom_range(1, 20);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_point(x, y, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        wait (pending_pairs.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[HW_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_HALF_WIDTH) half_w = val & 16'h3FFF;
        else                       mlimit = val & 8'hFF;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------- receiver ----------------
    always @(negedge aclk) begin
        logic [15:0] pat;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (rx_always) begin
            m_tready <= 1'b1;
        end else begin
            pat = $urandom;
            m_tready <= pat[3:0] != 4'd0 ? pat[4] | pat[5] : 1'b0;
        end
    end

    always @(posedge aclk) begin
        pair_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tlast, m_tdata};
            if (pending_pairs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pair %h at cycle %0d", got, cycles);
            end else begin
                want = pending_pairs.pop_front();
                if (got.lx !== want.lx || got.ly !== want.ly || got.rx !== want.rx ||
                    got.ry !== want.ry || got.fin !== want.fin) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pair mismatch: exp lx %h ly %h rx %h ry %h last %b, got lx %h ly %h rx %h ry %h last %b",
                                 want.lx, want.ly, want.rx, want.ry, want.fin,
                                 got.lx, got.ly, got.rx, got.ry, got.fin);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [15:0] next_coord(input logic [15:0] prev);
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return 16'($urandom);
            2:       return prev;
            3, 4, 5: return prev + 16'($urandom_range(0, 8191)) - 16'd4096;
            default: return prev + 16'($urandom_range(0, 255)) - 16'd128;
        endcase
    endfunction

    task automatic random_line();
        int n;
        logic [15:0] x, y;
        n = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 8);
        x = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16383)) - 16'd8192;
        y = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16383)) - 16'd8192;
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                x = next_coord(x);
                y = next_coord(y);
            end
            send_point(x, y, i == n - 1);
        end
    endtask

    task automatic test_directed_shapes();
        // straight run, right angle, hairpin, acute spike, repeated point
        send_point(16'h0000, 16'h0000, 0);
        send_point(16'h1000, 16'h0000, 0);
        send_point(16'h2000, 16'h0000, 0);
        send_point(16'h2000, 16'h1000, 0);
        send_point(16'h1000, 16'h1000, 0);
        send_point(16'h2000, 16'h1010, 0);
        send_point(16'h2000, 16'h1010, 0);
        send_point(16'h1000, 16'h1000, 1);
        // lone point
        send_point(16'h1234, 16'hABCD, 1);
        // extremes and saturation
        send_point(16'h7FFF, 16'h7FFF, 0);
        send_point(16'h8000, 16'h8000, 0);
        send_point(16'h7FFF, 16'h8000, 0);
        send_point(16'h8000, 16'h7FFF, 1);
        // zero-length two-point line
        send_point(16'hFFFF, 16'h0001, 0);
        send_point(16'hFFFF, 16'h0001, 1);
        go_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_HALF_WIDTH, 16383);
        write_reg(CFG_MITRE_LIMIT, 16);
        test_directed_shapes();
        write_reg(CFG_HALF_WIDTH, 0);
        write_reg(CFG_MITRE_LIMIT, 255);
        test_directed_shapes();
    endtask

    task automatic test_random_lines(input int target);
        while (items_sent < target) random_line();
        go_idle();
    endtask

    task automatic test_output_hold();
        hold_cycles = 3000;
        for (int i = 0; i < 12; i++) random_line();
        go_idle();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HALF_WIDTH;
        cfg_data = '0;
        half_w = HALF_WIDTH_RST;
        mlimit = MITRE_LIMIT_RST;
        old_x = 0; old_y = 0; cur_x = 0; cur_y = 0; held = 0;
        mismatches = 0; items_sent = 0; cycles = 0; burst_left = 0; hold_cycles = 0;
        rx_always = 1'b0; tx_no_gaps = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_shapes();
        test_register_extremes();

        write_reg(CFG_HALF_WIDTH, 410);
        write_reg(CFG_MITRE_LIMIT, 64);
        test_random_lines(500);

        tx_no_gaps = 1'b1;
        rx_always  = 1'b1;
        write_reg(CFG_HALF_WIDTH, $urandom_range(0, 16383));
        write_reg(CFG_MITRE_LIMIT, $urandom_range(16, 255));
        test_random_lines(800);

        tx_no_gaps = 1'b0;
        rx_always  = 1'b0;
        test_output_hold();

        write_reg(CFG_HALF_WIDTH, 16383);
        write_reg(CFG_MITRE_LIMIT, 255);
        test_random_lines(1100);
        write_reg(CFG_HALF_WIDTH, $urandom_range(1, 2000));
        write_reg(CFG_MITRE_LIMIT, 16);
        test_random_lines(1400);
        write_reg(CFG_HALF_WIDTH, $urandom_range(0, 16383));
        write_reg(CFG_MITRE_LIMIT, $urandom_range(16, 255));
        test_random_lines(N_ITEMS);

        if (mismatches == 0 && pending_pairs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
